// ----- hw/rtl/hgu_pkg.sv -----
// shared constants and types for the 2d uniform-bin histogram
// no dependencies; used by hgu_axis and histogram_2d_uniform_bins_top
`timescale 1ns / 1ps

package hgu_pkg;

  // counter store
  localparam int unsigned MaxCells = 4096;
  localparam int unsigned AddrW    = $clog2(MaxCells);
  localparam int unsigned CntW     = 32;

  // fixed field widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned BinsW   = 13;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CellW   = 2 * BinsW + 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegXLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBinsX  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBinsY  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegXScale = 3'd6;
  localparam logic [CfgIdxW-1:0] RegYScale = 3'd7;

  // item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindRead   = 1'b1;

  // stage loads for the per-axis binning pipe
  typedef struct packed {
    logic ld_mul;
    logic ld_bin;
  } axis_ctl_t;

endpackage

// ----- hw/rtl/hgu_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module hgu_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/hgu_axis.sv -----
// one axis of the binning pipe: range check and scale multiply, then bin clamp
// depends on hgu_pkg
`timescale 1ns / 1ps

module hgu_axis (
  input  logic                        clk_i,
  input  hgu_pkg::axis_ctl_t          ctl_i,
  input  logic [hgu_pkg::SampleW-1:0] v_i,
  input  logic [hgu_pkg::SampleW-1:0] lo_i,
  input  logic [hgu_pkg::SampleW-1:0] hi_i,
  input  logic [hgu_pkg::SampleW-1:0] scale_i,
  input  logic [hgu_pkg::BinsW-1:0]   nbins_i,
  output logic [hgu_pkg::BinsW-1:0]   bin_o,
  output logic                        ok_o
);

  localparam int unsigned W = hgu_pkg::SampleW;

  logic [W-1:0]   diff;
  logic           in_rng;
  logic [2*W-1:0] prod_d;
  logic [2*W-1:0] prod_q;
  logic           rng_q;
  logic           at_hi_q;

  logic [W-1:0]   whole;
  logic           over;
  logic [hgu_pkg::BinsW-1:0] bin_d;
  logic           ok_d;

  // stage 1: window test and Q32.32 product of offset and scale
  assign diff   = v_i - lo_i;
  assign in_rng = (nbins_i != '0) && ($signed(v_i) >= $signed(lo_i))
                  && ($signed(v_i) <= $signed(hi_i));
  assign prod_d = (2*W)'(diff) * (2*W)'(scale_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_mul) begin
      prod_q  <= prod_d;
      rng_q   <= in_rng;
      at_hi_q <= (v_i == hi_i);
    end
  end

  // stage 2: integer part, overshoot to last bin only at the upper edge
  assign whole = prod_q[2*W-1:W];
  assign over  = whole >= W'(nbins_i);

  always_comb begin
    bin_d = whole[hgu_pkg::BinsW-1:0];
    ok_d  = rng_q;
    if (over) begin
      bin_d = nbins_i - hgu_pkg::BinsW'(1);
      ok_d  = rng_q && at_hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_bin) begin
      bin_o <= bin_d;
      ok_o  <= ok_d;
    end
  end

endmodule

// ----- hw/rtl/histogram_2d_uniform_bins_top.sv -----
// top level of the 2d uniform-bin histogram: config registers, sequencer,
// counter ram with its clearing pass, result register
// depends on hgu_pkg, hgu_axis, hgu_ram
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   kind_i x_sample_i y_sample_i cell_index_i
//   out      source     out_valid_o / out_stall_i accepted_o cell_res_o count_o
//   cfg      sink       cfg_we_i                  cfg_idx_i cfg_data_i
//
// each word passes from acceptance to the result register through window
// test and scale multiply, bin clamp, cell multiply-add, ram read, then the
// read-modify-write of the counter; only one word is in flight, so a new word
// is taken only after the last has left the write step and returned to idle
// after reset a clearing pass zeroes all 4096 counters, one per cycle, with
// in_stall_o high throughout (config writes are still taken)
// a new word is accepted while a finished result waits on a stalled output;
// only the final write step waits for the result register to free up
`timescale 1ns / 1ps

module histogram_2d_uniform_bins_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [hgu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hgu_pkg::CfgW-1:0]    cfg_data_i,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [hgu_pkg::SampleW-1:0] x_sample_i,
  input  logic [hgu_pkg::SampleW-1:0] y_sample_i,
  input  logic [hgu_pkg::IdxW-1:0]    cell_index_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic [hgu_pkg::IdxW-1:0]    cell_res_o,
  output logic [hgu_pkg::CntW-1:0]    count_o
);

  localparam int unsigned AddrW = hgu_pkg::AddrW;
  localparam int unsigned CntW  = hgu_pkg::CntW;
  localparam int unsigned CellW = hgu_pkg::CellW;
  localparam int unsigned BinsW = hgu_pkg::BinsW;
  localparam int unsigned SW    = hgu_pkg::SampleW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_BIN,
    S_CELL,
    S_READ,
    S_WRITE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [SW-1:0]    x_low_q, x_high_q, y_low_q, y_high_q;
  logic [SW-1:0]    x_scale_q, y_scale_q;
  logic [BinsW-1:0] bins_x_q, bins_y_q;

  // word under work
  logic                    kind_q;
  logic [SW-1:0]           xs_q, ys_q;
  logic [hgu_pkg::IdxW-1:0] idx_q;
  logic [AddrW-1:0]        cell_q;
  logic                    hit_q;

  // clearing pass
  logic [AddrW:0] clr_q;

  // result register
  logic                     out_valid_q;
  logic                     accepted_q;
  logic [hgu_pkg::IdxW-1:0] cell_res_q;
  logic [CntW-1:0]          count_q;

  // axis pipes
  hgu_pkg::axis_ctl_t axis_ctl;
  logic [BinsW-1:0]   bx, by;
  logic               x_ok, y_ok;

  // cell arithmetic
  logic [2*BinsW-1:0] row_off;
  logic [CellW-1:0]   cell_full;
  logic               cell_in_store;
  logic               idx_in_store;

  // ram ports
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [CntW-1:0]  ram_wdata, ram_rdata;
  logic [CntW-1:0]  bumped;

  logic in_take;
  logic out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q   <= '0;
      x_high_q  <= SW'(65536);
      y_low_q   <= '0;
      y_high_q  <= SW'(65536);
      bins_x_q  <= BinsW'(64);
      bins_y_q  <= BinsW'(64);
      x_scale_q <= SW'(4194304);
      y_scale_q <= SW'(4194304);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hgu_pkg::RegXLow:   x_low_q   <= cfg_data_i;
        hgu_pkg::RegXHigh:  x_high_q  <= cfg_data_i;
        hgu_pkg::RegYLow:   y_low_q   <= cfg_data_i;
        hgu_pkg::RegYHigh:  y_high_q  <= cfg_data_i;
        hgu_pkg::RegBinsX:  bins_x_q  <= cfg_data_i[BinsW-1:0];
        hgu_pkg::RegBinsY:  bins_y_q  <= cfg_data_i[BinsW-1:0];
        hgu_pkg::RegXScale: x_scale_q <= cfg_data_i;
        hgu_pkg::RegYScale: y_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // binning pipes, one per axis
  assign axis_ctl.ld_mul = (state_q == S_MUL);
  assign axis_ctl.ld_bin = (state_q == S_BIN);

  hgu_axis u_axis_x (
    .clk_i   (clk_i),
    .ctl_i   (axis_ctl),
    .v_i     (xs_q),
    .lo_i    (x_low_q),
    .hi_i    (x_high_q),
    .scale_i (x_scale_q),
    .nbins_i (bins_x_q),
    .bin_o   (bx),
    .ok_o    (x_ok)
  );

  hgu_axis u_axis_y (
    .clk_i   (clk_i),
    .ctl_i   (axis_ctl),
    .v_i     (ys_q),
    .lo_i    (y_low_q),
    .hi_i    (y_high_q),
    .scale_i (y_scale_q),
    .nbins_i (bins_y_q),
    .bin_o   (by),
    .ok_o    (y_ok)
  );

  // linear cell = bx + by * bins_x, dropped when past the store
  assign row_off       = (2*BinsW)'(by) * (2*BinsW)'(bins_x_q);
  assign cell_full     = CellW'(row_off) + CellW'(bx);
  assign cell_in_store = cell_full < CellW'(hgu_pkg::MaxCells);
  assign idx_in_store  = 32'(idx_q) < 32'(hgu_pkg::MaxCells);

  // saturating increment
  assign bumped = (ram_rdata == '1) ? ram_rdata : ram_rdata + CntW'(1);

  // ram write port shared by the clearing pass and the counter update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_q;
    ram_wdata = (kind_q == hgu_pkg::KindRead) ? '0 : bumped;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q[AddrW-1:0];
      ram_wdata = '0;
    end else if (state_q == S_WRITE && out_free && hit_q) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state_q == S_READ) && hit_q;

  hgu_ram #(
    .Depth (hgu_pkg::MaxCells),
    .Width (CntW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_q),
    .rdata_o (ram_rdata)
  );

  // sequencer: one word at a time, so no two counter accesses overlap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + (AddrW+1)'(1);
          if (clr_q == (AddrW+1)'(hgu_pkg::MaxCells - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_BIN;
        S_BIN:   state_q <= S_CELL;
        S_CELL:  state_q <= S_READ;
        S_READ:  state_q <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // word payload and cell address
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      xs_q   <= x_sample_i;
      ys_q   <= y_sample_i;
      idx_q  <= cell_index_i;
    end
    if (state_q == S_CELL) begin
      if (kind_q == hgu_pkg::KindRead) begin
        cell_q <= AddrW'(idx_q);
        hit_q  <= idx_in_store;
      end else begin
        cell_q <= AddrW'(cell_full);
        hit_q  <= x_ok && y_ok && cell_in_store;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_WRITE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE && out_free) begin
      if (kind_q == hgu_pkg::KindRead) begin
        accepted_q <= 1'b0;
        cell_res_q <= idx_q;
        count_q    <= hit_q ? ram_rdata : '0;
      end else begin
        accepted_q <= hit_q;
        cell_res_q <= hit_q ? hgu_pkg::IdxW'(cell_q) : '0;
        count_q    <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign cell_res_o  = cell_res_q;
  assign count_o     = count_q;

endmodule
